/* design/fqp_pkg.sv */
// Shared constants for the key queue with promote-to-head.
package fqp_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 30;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 30;

    localparam logic [FUNC_W-1:0] FN_ENQ     = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_PROMOTE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

/* design/fifo_queue_with_promote_unit.sv */
// Top level of the key queue with enqueue, dequeue, peek and promote-to-head.
//
//  Channel   Signals                                Direction  Handshake
//  --------  -------------------------------------  ---------  ---------------------------
//  command   start, busy, func, key                 in         taken when start && !busy
//  result    done, status, head_key, count,         out        one-cycle strobe on done,
//            is_empty                                          cannot be held off
//
// Enqueue and every refused command give their result in the cycle after the
// transaction; dequeue and peek read the head key through the registered port.
// Promote scans from the head to a match (up to the fill), then, unless it is
// the head, moves each entry in front of it one place towards the tail and puts
// the key at the head. The single read and single write port of the key memory
// set these steps. Reset empties the queue at once; no clearing pass is needed,
// since only live entries are ever read. The receiver cannot stall; busy is low
// again in the cycle in which done is shown.
module fifo_queue_with_promote_unit #(
    parameter int DEPTH    = fqp_pkg::DEPTH_DEF,
    parameter int KEY_BITS = fqp_pkg::KEY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fqp_pkg::FUNC_W-1:0]  func,
    input  logic [fqp_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [fqp_pkg::STAT_W-1:0]  status,
    output logic [fqp_pkg::KEY_W-1:0]   head_key,
    output logic [fqp_pkg::COUNT_W-1:0] count,
    output logic                        is_empty
);

    // Stored key width: keys are cut to KEY_BITS and to the port width.
    localparam int SW = (KEY_BITS < fqp_pkg::KEY_W) ? KEY_BITS : fqp_pkg::KEY_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [FW-1:0]                    fill_reg, fill_next;
    logic [AW-1:0]                    head_reg, head_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    logic [fqp_pkg::FUNC_W-1:0]       func_reg, func_next;
    logic [SW-1:0]                    key_reg, key_next;
    logic                             done_reg, done_next;
    logic [fqp_pkg::STAT_W-1:0]       status_reg, status_next;
    logic [fqp_pkg::KEY_W-1:0]        hkey_reg, hkey_next;

    logic          mem_we;
    logic [AW-1:0] wr_off, rd_off;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [SW-1:0] mem_wdata, mem_rdata;

    // The queue lives in a ring: logical offset 0 is the head slot.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign mem_waddr = ring_addr(head_reg, wr_off);
    assign mem_raddr = ring_addr(head_reg, rd_off);

    fqp_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        hkey_next   = hkey_reg;
        mem_we      = 1'b0;
        wr_off      = idx_reg;
        rd_off      = '0;
        mem_wdata   = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    key_next  = key[SW-1:0];
                    idx_next  = '0;
                    hkey_next = '0;
                    unique case (func)
                        fqp_pkg::FN_ENQ:
                        begin
                            done_next = 1'b1;
                            if (fill_reg == FW'(DEPTH))
                            begin
                                status_next = fqp_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                wr_off      = fill_reg[AW-1:0];
                                mem_wdata   = key[SW-1:0];
                                fill_next   = fill_reg + FW'(1);
                                status_next = fqp_pkg::ST_OK;
                            end
                        end
                        fqp_pkg::FN_DEQ, fqp_pkg::FN_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = fqp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        fqp_pkg::FN_PROMOTE:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = fqp_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                // The head key arrives from the memory this cycle.
                hkey_next   = fqp_pkg::KEY_W'(mem_rdata);
                status_next = fqp_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                if (func_reg == fqp_pkg::FN_DEQ)
                begin
                    head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    fill_next = fill_reg - FW'(1);
                end
            end

            S_SCAN:
            begin
                if (mem_rdata == key_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        status_next = fqp_pkg::ST_OK;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_off     = idx_reg - AW'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (FW'(idx_reg) + FW'(1) == fill_reg)
                begin
                    status_next = fqp_pkg::ST_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_off   = idx_reg + AW'(1);
                end
            end

            S_SHIFT:
            begin
                // Move the entry in front of idx one place towards the tail.
                mem_we    = 1'b1;
                wr_off    = idx_reg;
                mem_wdata = mem_rdata;
                if (idx_reg == AW'(1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    rd_off   = idx_reg - AW'(2);
                end
            end

            S_PLACE:
            begin
                mem_we      = 1'b1;
                wr_off      = '0;
                mem_wdata   = key_reg;
                status_next = fqp_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        func_reg   <= func_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        hkey_reg   <= hkey_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign head_key = hkey_reg;
    assign count    = fqp_pkg::COUNT_W'(fill_reg);
    assign is_empty = (fill_reg == '0);

endmodule

/* design/fqp_mem.sv */
// Key storage: one write port and one read port with registered read data.
module fqp_mem #(
    parameter int DEPTH = fqp_pkg::DEPTH_DEF,
    parameter int WIDTH = fqp_pkg::KEY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the key queue with promote-to-head.
module tb;

    // The queue is built with its default depth, and the predictor keeps the same bound.
    localparam int QUEUE_DEPTH = fqp_pkg::DEPTH_DEF;

    // This is the worst command latency, a promote of the tail key of a full queue,
    // with a margin added.
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;

    // This is the number of random transactions in each of the three traffic phases.
    localparam int PHASE_ITEMS = 634;

    // One expected result, held field by field as the result ports present it.
    typedef struct packed {
        logic [fqp_pkg::STAT_W-1:0]  status;
        logic [fqp_pkg::KEY_W-1:0]   head_key;
        logic [fqp_pkg::COUNT_W-1:0] count;
        logic                        is_empty;
    } queue_result_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [fqp_pkg::FUNC_W-1:0]  func  = fqp_pkg::FN_ENQ;
    logic [fqp_pkg::KEY_W-1:0]   key   = '0;
    logic                        busy;
    logic                        done;
    logic [fqp_pkg::STAT_W-1:0]  status;
    logic [fqp_pkg::KEY_W-1:0]   head_key;
    logic [fqp_pkg::COUNT_W-1:0] count;
    logic                        is_empty;

    // The predictor's copy of the queue contents. Entry 0 is the head.
    logic [fqp_pkg::KEY_W-1:0] model_keys[$];

    // Results that have been predicted but not yet seen on the result ports, oldest first.
    queue_result_t    expected_results[$];

    int               mismatch_count   = 0;
    int               sender_idle_pct  = 0;

    fifo_queue_with_promote_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .key      (key),
        .done     (done),
        .status   (status),
        .head_key (head_key),
        .count    (count),
        .is_empty (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // This is a safety net against a hung handshake. The run normally needs well
    // under a tenth of this time.
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Each mismatch prints one line and is counted. The run carries on afterwards, so
    // that one fault does not hide others.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    // This applies one command to the predictor's queue and returns the result that
    // the block ought to give. A full enqueue, an empty dequeue or peek, and a promote
    // of an absent key all leave the queue untouched. A promote moves only the first
    // match counted from the head, which covers duplicate keys and a promote of the
    // head itself.
    function automatic queue_result_t apply_queue_op(input logic [fqp_pkg::FUNC_W-1:0] op,
                                                     input logic [fqp_pkg::KEY_W-1:0]  k);
        queue_result_t             res;
        int                        pos;
        logic [fqp_pkg::KEY_W-1:0] moved;
        res = '0;
        res.status = fqp_pkg::ST_OK;
        case (op)
            fqp_pkg::FN_ENQ:
            begin
                if (model_keys.size() >= QUEUE_DEPTH)
                    res.status = fqp_pkg::ST_FULL;
                else
                    model_keys.push_back(k);
            end
            fqp_pkg::FN_DEQ:
            begin
                if (model_keys.size() == 0)
                    res.status = fqp_pkg::ST_EMPTY;
                else
                    res.head_key = model_keys.pop_front();
            end
            fqp_pkg::FN_PEEK:
            begin
                if (model_keys.size() == 0)
                    res.status = fqp_pkg::ST_EMPTY;
                else
                    res.head_key = model_keys[0];
            end
            fqp_pkg::FN_PROMOTE:
            begin
                pos = -1;
                for (int i = 0; i < model_keys.size(); i++)
                begin
                    if (model_keys[i] == k)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos < 0)
                    res.status = fqp_pkg::ST_NOTFOUND;
                else
                begin
                    moved = model_keys[pos];
                    model_keys.delete(pos);
                    model_keys.push_front(moved);
                end
            end
        endcase
        res.count    = fqp_pkg::COUNT_W'(model_keys.size());
        res.is_empty = (model_keys.size() == 0);
        return res;
    endfunction

    // This is the checker and predictor in one process. Every port is sampled at the
    // rising edge, before the edge's own updates land. A result strobe is matched
    // against the oldest expectation first. After that, a transaction accepted at the
    // same edge is predicted, so that a new command taken in the cycle of a done strobe
    // is queued behind the result that is being checked.
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no command outstanding", 32'd0, 32'd1);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (head_key !== want.head_key)
                        report_mismatch("head_key", 32'(want.head_key), 32'(head_key));
                    if (count !== want.count)
                        report_mismatch("count", 32'(want.count), 32'(count));
                    if (is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(want.is_empty), 32'(is_empty));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_results.push_back(apply_queue_op(func, key));
        end
    end

    // This offers one command and returns at the edge at which the block takes it.
    // Start is left high, so that a following command can be presented back to back
    // at that same edge. A random number of idle cycles comes first, with noise on the
    // payload while start is low.
    task automatic send_command(input logic [fqp_pkg::FUNC_W-1:0] op,
                                input logic [fqp_pkg::KEY_W-1:0]  k);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            func  <= fqp_pkg::FUNC_W'($urandom);
            key   <= fqp_pkg::KEY_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        func  <= op;
        key   <= k;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // This draws a key that often hits the queue's present contents or a small pool, so
    // that promotes find matches and duplicates build up. Otherwise it draws a key over
    // the full 30-bit range.
    function automatic logic [fqp_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45 && model_keys.size() > 0)
            return model_keys[$urandom_range(model_keys.size() - 1)];
        else if (r < 65)
            return fqp_pkg::KEY_W'($urandom_range(7));
        else
            return fqp_pkg::KEY_W'($urandom);
    endfunction

    // The commands that an empty queue must refuse: dequeue and peek report empty, and
    // a promote can find nothing.
    task automatic test_empty_queue();
        send_command(fqp_pkg::FN_PEEK, '1);
        send_command(fqp_pkg::FN_DEQ, '0);
        send_command(fqp_pkg::FN_PROMOTE, '0);
    endtask

    // This fills the queue to the brim with both extreme keys and one duplicate, and
    // then tries one enqueue too many.
    task automatic test_fill_and_overflow();
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i == 0)
                send_command(fqp_pkg::FN_ENQ, '1);
            else if (i == QUEUE_DEPTH - 1)
                send_command(fqp_pkg::FN_ENQ, '0);
            else if (i == 3 || i == 9)
                send_command(fqp_pkg::FN_ENQ, fqp_pkg::KEY_W'('h155));
            else
                send_command(fqp_pkg::FN_ENQ, fqp_pkg::KEY_W'($urandom));
        end
        send_command(fqp_pkg::FN_ENQ, fqp_pkg::KEY_W'('h2AAA_AAAA));
    endtask

    // The promote cases on a full queue. The tail key is promoted, which is the longest
    // scan and shift. That key is then promoted again, now as the head. Next comes the
    // duplicated key, of which only the first copy may move. Last is a key that is
    // absent. A peek and a dequeue then show the new head.
    task automatic test_promote_cases();
        send_command(fqp_pkg::FN_PROMOTE, '0);
        send_command(fqp_pkg::FN_PROMOTE, '0);
        send_command(fqp_pkg::FN_PROMOTE, fqp_pkg::KEY_W'('h155));
        send_command(fqp_pkg::FN_PROMOTE, fqp_pkg::KEY_W'('h2AAA_AAAA));
        send_command(fqp_pkg::FN_PEEK, fqp_pkg::KEY_W'($urandom));
        send_command(fqp_pkg::FN_DEQ, fqp_pkg::KEY_W'($urandom));
    endtask

    // This is random traffic that swings between filling and draining. The queue
    // therefore passes through full and empty many times, and a promote meets every
    // fill level along the way.
    task automatic test_random_traffic(input int items, input int idle_pct);
        bit                         growing;
        int                         r;
        logic [fqp_pkg::FUNC_W-1:0] op;
        sender_idle_pct = idle_pct;
        growing = 1'b1;
        for (int n = 0; n < items; n++)
        begin
            if (model_keys.size() >= QUEUE_DEPTH && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (model_keys.size() == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            else if ($urandom_range(59) == 0)
                growing = !growing;
            r = $urandom_range(99);
            if (growing)
                op = (r < 40) ? fqp_pkg::FN_ENQ :
                     (r < 55) ? fqp_pkg::FN_DEQ :
                     (r < 70) ? fqp_pkg::FN_PEEK : fqp_pkg::FN_PROMOTE;
            else
                op = (r < 15) ? fqp_pkg::FN_ENQ :
                     (r < 50) ? fqp_pkg::FN_DEQ :
                     (r < 65) ? fqp_pkg::FN_PEEK : fqp_pkg::FN_PROMOTE;
            send_command(op, pick_key());
        end
    endtask

    // This withdraws start and waits for every outstanding result, within a limit. It
    // then lets the block's worst latency pass, so that a stray late strobe is caught.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (expected_results.size() != 0 && guard < 20 * DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never produced", 32'(expected_results.size()), 32'd0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 21;
        test_empty_queue();
        test_fill_and_overflow();
        test_promote_cases();

        // The sender is idle for about a fifth of the time, then for most of it, then
        // never, which gives back-to-back transactions.
        test_random_traffic(PHASE_ITEMS, 21);
        test_random_traffic(PHASE_ITEMS, 73);
        test_random_traffic(PHASE_ITEMS, 0);

        wait_for_drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
